// File: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
// Package for the JSON string unescape block.
// Phase type, result kind and error codes, character constants, decode helpers.
// No dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX  = 3'd3
    } t_phase;

    typedef logic [1:0] t_kind;
    typedef logic [2:0] t_err;

    localparam t_kind KIND_BYTE = 2'd0;
    localparam t_kind KIND_DONE = 2'd1;
    localparam t_kind KIND_ERR  = 2'd2;

    localparam t_err ERR_NONE      = 3'd0;
    localparam t_err ERR_NO_QUOTE  = 3'd1;
    localparam t_err ERR_CTRL      = 3'd2;
    localparam t_err ERR_END_ESC   = 3'd3;
    localparam t_err ERR_BAD_ESC   = 3'd4;
    localparam t_err ERR_END_HEX   = 3'd5;
    localparam t_err ERR_BAD_HEX   = 3'd6;
    localparam t_err ERR_UNTERM    = 3'd7;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [15:0] CP_MAX1 = 16'h007f;
    localparam logic [15:0] CP_MAX2 = 16'h07ff;

    localparam int MAX_RES = 3;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // {valid, byte}
    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h22: r = {1'b1, 8'h22};
            8'h5c: r = {1'b1, 8'h5c};
            8'h2f: r = {1'b1, 8'h2f};
            8'h62: r = {1'b1, 8'h08};
            8'h66: r = {1'b1, 8'h0c};
            8'h6e: r = {1'b1, 8'h0a};
            8'h72: r = {1'b1, 8'h0d};
            8'h74: r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/jsu_if.sv
`timescale 1ns / 1ps
// Word channels of the JSON string unescape block: input and result.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] err_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output err_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input err_code,
                    input last, output ready);
endinterface

// File: rtl/core/json_string_unescape.sv
`timescale 1ns / 1ps
// JSON string literal decoder with \uXXXX to UTF-8 conversion.
// The first result word of an accepted input word is shown in the cycle after it is accepted.
// Throughput: one input word per cycle while each causes at most one result and the receiver is ready;
// an item with several results stalls the input until its final word leaves (1 result word/cycle when ready).
// Reset (synchronous, active low): idle awaiting opening quote, result buffer empty.
module json_string_unescape (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_out
);
    import jsu_pkg::*;

    // decoder state
    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_code, n_code;

    // result buffer: slot 0 faces the output, later slots shift down on take
    logic [7:0]  r_byte [MAX_RES];
    t_kind       r_kind [MAX_RES];
    t_err        r_err  [MAX_RES];
    logic        r_last [MAX_RES];
    logic [1:0]  r_left;

    // decoded results of the word at the input
    logic [7:0]  d_byte [MAX_RES];
    t_kind       d_kind [MAX_RES];
    t_err        d_err  [MAX_RES];
    logic [1:0]  d_cnt;

    logic        w_accept, w_take;
    logic [4:0]  w_hex;
    logic [8:0]  w_esc;
    logic [15:0] w_acc;
    logic [7:0]  w_c;

    assign w_take   = (r_left != 2'd0) && o_out.ready;
    // take a new word once the buffer is empty, or as its final word leaves
    assign i_in.ready = (r_left == 2'd0) || ((r_left == 2'd1) && o_out.ready);
    assign w_accept = i_in.valid && i_in.ready;

    assign w_c   = i_in.data_byte;
    assign w_hex = hex_value(w_c);
    assign w_esc = escape_byte(w_c);
    assign w_acc = {r_code[11:0], w_hex[3:0]};

    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_code  = r_code;
        d_cnt   = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            d_byte[i] = 8'd0;
            d_kind[i] = KIND_BYTE;
            d_err[i]  = ERR_NONE;
        end

        case (r_phase)
            PH_STR: begin
                if (i_in.cmd) begin
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = ERR_UNTERM;
                end else if (w_c == CH_QUOTE) begin
                    d_kind[0] = KIND_DONE;
                end else if (w_c < CH_SPACE) begin
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = ERR_CTRL;
                end else if (w_c != CH_BSLASH) begin
                    d_byte[0] = w_c;
                end
                if (i_in.cmd || w_c == CH_QUOTE || w_c < CH_SPACE) begin
                    n_phase = PH_IDLE;
                    d_cnt   = 2'd1;
                end else if (w_c == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    d_cnt = 2'd1;
                end
            end
            PH_ESC: begin
                d_cnt = 2'd1;
                if (i_in.cmd) begin
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = ERR_END_ESC;
                    n_phase   = PH_IDLE;
                end else if (w_c == CH_U) begin
                    d_cnt   = 2'd0;
                    n_phase = PH_HEX;
                end else if (w_esc[8]) begin
                    d_byte[0] = w_esc[7:0];
                    n_phase   = PH_STR;
                end else begin
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = ERR_BAD_ESC;
                    n_phase   = PH_IDLE;
                end
                n_hex  = 2'd0;
                n_code = 16'd0;
            end
            PH_HEX: begin
                if (i_in.cmd || !w_hex[4]) begin
                    d_cnt     = 2'd1;
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = i_in.cmd ? ERR_END_HEX : ERR_BAD_HEX;
                    n_phase   = PH_IDLE;
                    n_hex     = 2'd0;
                    n_code    = 16'd0;
                end else begin
                    n_code = w_acc;
                    n_hex  = r_hex + 2'd1;
                    if (r_hex == 2'd3) begin
                        n_phase = PH_STR;
                        if (w_acc <= CP_MAX1) begin
                            d_cnt     = 2'd1;
                            d_byte[0] = w_acc[7:0];
                        end else if (w_acc <= CP_MAX2) begin
                            d_cnt     = 2'd2;
                            d_byte[0] = {3'b110, w_acc[10:6]};
                            d_byte[1] = {2'b10, w_acc[5:0]};
                        end else begin
                            d_cnt     = 2'd3;
                            d_byte[0] = {4'b1110, w_acc[15:12]};
                            d_byte[1] = {2'b10, w_acc[11:6]};
                            d_byte[2] = {2'b10, w_acc[5:0]};
                        end
                    end
                end
            end
            default: begin
                n_hex  = 2'd0;
                n_code = 16'd0;
                if (i_in.cmd || w_c != CH_QUOTE) begin
                    d_cnt     = 2'd1;
                    d_kind[0] = KIND_ERR;
                    d_err[0]  = ERR_NO_QUOTE;
                    n_phase   = PH_IDLE;
                end else begin
                    n_phase = PH_STR;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hex   <= 2'd0;
            r_code  <= 16'd0;
            r_left  <= 2'd0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_hex   <= n_hex;
                r_code  <= n_code;
                r_left  <= d_cnt;
            end else if (w_take) begin
                r_left  <= r_left - 2'd1;
            end
        end
    end

    // result slots, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_byte[i] <= d_byte[i];
                r_kind[i] <= d_kind[i];
                r_err[i]  <= d_err[i];
                r_last[i] <= (d_cnt == 2'(i + 1));
            end
        end else if (w_take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_byte[i] <= r_byte[i + 1];
                r_kind[i] <= r_kind[i + 1];
                r_err[i]  <= r_err[i + 1];
                r_last[i] <= r_last[i + 1];
            end
        end
    end

    assign o_out.valid    = (r_left != 2'd0);
    assign o_out.out_byte = r_byte[0];
    assign o_out.kind     = r_kind[0];
    assign o_out.err_code = r_err[0];
    assign o_out.last     = r_last[0];

endmodule

// File: rtl/core/jsu_checker.sv
`timescale 1ns / 1ps
// Port-level checks for json_string_unescape, with the bind that attaches them.
// Depends on jsu_pkg and the top level.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_kind,
    input logic [2:0] i_err_code,
    input logic       i_last
);
    import jsu_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_kind) && $stable(i_err_code) && $stable(i_last))
        else $error("result word changed while stalled");

    // nothing buffered means input open
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty result buffer");

    // done and error words close their item and carry clean fields
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_DONE |->
            i_last && i_err_code == ERR_NONE && i_out_byte == 8'd0)
        else $error("malformed done word");

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_ERR |->
            i_last && i_err_code != ERR_NONE && i_out_byte == 8'd0)
        else $error("malformed error word");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word shown after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_kind       (o_out.kind),
    .i_err_code   (o_out.err_code),
    .i_last       (o_out.last)
);

// File: tb/tb_json_string_unescape.sv
`timescale 1ns / 1ps
// Testbench for json_string_unescape: directed and random byte streams, each result word
// checked against an in-bench decoder. Needs jsu_pkg, jsu_in_if/jsu_out_if and the RTL.
module tb_json_string_unescape;
    import jsu_pkg::*;

    // Quiet-cycle limit, set with a wide margin over the longest run without a handshake that
    // the random sender gaps, receiver stalls and the end drain can be expected to yield.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_WORDS   = 340;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_err       err;
        logic       last;
    } t_res_word;

    // Decoder state, plus the result words the block still owes us, oldest first.
    class unescape_board;
        t_phase      phase;
        logic [1:0]  n_hex;
        logic [15:0] code_pt;
        t_res_word   owed[$];
        t_res_word   fresh[$];
        int          faults;

        function new();
            phase   = PH_IDLE;
            n_hex   = 2'd0;
            code_pt = 16'd0;
            faults  = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void flag(string msg);
            faults++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void add(logic [7:0] data, t_kind kind, t_err err);
            fresh.insert(fresh.size(), t_res_word'{data, kind, err, 1'b0});
        endfunction

        // Any error drops the string and goes back to hunting for a quote.
        function void abort(t_err err);
            phase   = PH_IDLE;
            n_hex   = 2'd0;
            code_pt = 16'd0;
            add(8'h00, KIND_ERR, err);
        endfunction

        // One accepted input word: advance the decoder, queue what it should emit.
        function void note_input(logic eoi, logic [7:0] c);
            logic [8:0] esc;    // {hit, byte}
            logic [4:0] nib;    // {hit, nibble}
            t_res_word  tail;
            fresh.delete();

            esc = 9'd0;
            case (c)
                CH_QUOTE:  esc = {1'b1, CH_QUOTE};
                CH_BSLASH: esc = {1'b1, CH_BSLASH};
                "/":       esc = {1'b1, 8'h2f};
                "b":       esc = {1'b1, 8'h08};
                "f":       esc = {1'b1, 8'h0c};
                "n":       esc = {1'b1, 8'h0a};
                "r":       esc = {1'b1, 8'h0d};
                "t":       esc = {1'b1, 8'h09};
                default:   esc = 9'd0;
            endcase

            nib = 5'd0;
            if (c >= "0" && c <= "9")
                nib = {1'b1, 4'(c - "0")};
            else if (c >= "a" && c <= "f")
                nib = {1'b1, 4'(c - "a" + 8'd10)};
            else if (c >= "A" && c <= "F")
                nib = {1'b1, 4'(c - "A" + 8'd10)};

            case (phase)
                PH_STR: begin
                    if (eoi)
                        abort(ERR_UNTERM);
                    else if (c == CH_QUOTE) begin
                        phase = PH_IDLE;
                        add(8'h00, KIND_DONE, ERR_NONE);
                    end else if (c < CH_SPACE)
                        abort(ERR_CTRL);
                    else if (c == CH_BSLASH)
                        phase = PH_ESC;
                    else
                        add(c, KIND_BYTE, ERR_NONE);
                end
                PH_ESC: begin
                    if (eoi)
                        abort(ERR_END_ESC);
                    else if (c == CH_U) begin
                        phase   = PH_HEX;
                        n_hex   = 2'd0;
                        code_pt = 16'd0;
                    end else if (!esc[8])
                        abort(ERR_BAD_ESC);
                    else begin
                        phase = PH_STR;
                        add(esc[7:0], KIND_BYTE, ERR_NONE);
                    end
                end
                PH_HEX: begin
                    if (eoi)
                        abort(ERR_END_HEX);
                    else if (!nib[4])
                        abort(ERR_BAD_HEX);
                    else begin
                        code_pt = {code_pt[11:0], nib[3:0]};
                        if (n_hex == 2'd3) begin
                            // fourth digit: emit the code point as UTF-8, no surrogate pairing
                            n_hex = 2'd0;
                            phase = PH_STR;
                            if (code_pt <= CP_MAX1)
                                add(code_pt[7:0], KIND_BYTE, ERR_NONE);
                            else if (code_pt <= CP_MAX2) begin
                                add({3'b110, code_pt[10:6]}, KIND_BYTE, ERR_NONE);
                                add({2'b10, code_pt[5:0]}, KIND_BYTE, ERR_NONE);
                            end else begin
                                add({4'b1110, code_pt[15:12]}, KIND_BYTE, ERR_NONE);
                                add({2'b10, code_pt[11:6]}, KIND_BYTE, ERR_NONE);
                                add({2'b10, code_pt[5:0]}, KIND_BYTE, ERR_NONE);
                            end
                        end else
                            n_hex = n_hex + 2'd1;
                    end
                end
                default: begin
                    if (eoi || c != CH_QUOTE)
                        abort(ERR_NO_QUOTE);
                    else begin
                        phase   = PH_STR;
                        n_hex   = 2'd0;
                        code_pt = 16'd0;
                    end
                end
            endcase

            if (fresh.size() > 0) begin
                tail      = fresh[fresh.size() - 1];
                tail.last = 1'b1;
                fresh[fresh.size() - 1] = tail;
            end
            foreach (fresh[i])
                owed.insert(owed.size(), fresh[i]);
        endfunction

        function void check_word(t_res_word got);
            t_res_word want;
            if (owed.size() == 0) begin
                flag($sformatf("result with none owed: byte %02h kind %0d err %0d last %0b",
                               got.data, got.kind, got.err, got.last));
                return;
            end
            want = owed.pop_front();
            if (got.data !== want.data || got.kind !== want.kind ||
                got.err !== want.err || got.last !== want.last)
                flag($sformatf({"mismatch: expected byte %02h kind %0d err %0d last %0b,",
                                " got byte %02h kind %0d err %0d last %0b"},
                               want.data, want.kind, want.err, want.last,
                               got.data, got.kind, got.err, got.last));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  in_if();
    jsu_out_if out_if();

    unescape_board board = new();

    int send_idle_pct  = 34;
    int recv_stall_pct = 51;
    int quiet_cycles   = 0;
    int words_sent     = 0;

    json_string_unescape i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Receiver back-pressure; stall rate set by the current idling phase.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both handshakes are sampled here, input first, so the prediction for a word is
    // always queued before any result it can cause. Also runs the quiet-cycle watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                board.note_input(in_if.cmd, in_if.data_byte);
            if (out_if.valid && out_if.ready)
                board.check_word(t_res_word'{out_if.out_byte, out_if.kind,
                                             out_if.err_code, out_if.last});
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // One input word: random sender gap, then hold valid until the block takes it.
    task automatic send_word(input logic eoi, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.cmd       <= eoi;
        in_if.data_byte <= c;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(1'b0, s[i]);
    endtask

    // Sender goes quiet until every owed result has come back.
    task automatic hold_until_drained();
        in_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (board.pending() > 0);
    endtask

    // Top-first hex digits of cp, letters in random case.
    task automatic send_hex_digits(input logic [15:0] cp, input int count);
        logic [3:0] nib;
        for (int i = 0; i < count; i++) begin
            nib = cp[15 - 4 * i -: 4];
            if (nib < 4'd10)
                send_word(1'b0, 8'("0" + nib));
            else
                send_word(1'b0, 8'(($urandom_range(1) ? "a" : "A") + nib - 4'd10));
        end
    endtask

    // \uXXXX spread over the one-, two- and three-byte UTF-8 ranges and their edges.
    task automatic send_unicode();
        logic [15:0] cp;
        logic [15:0] edges [8] = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff,
                                   16'h0800, 16'hd800, 16'hdfff, 16'hffff};
        case ($urandom_range(9))
            0, 1, 2: cp = 16'($urandom_range(16'h007f));
            3, 4, 5: cp = 16'($urandom_range(16'h07ff, 16'h0080));
            6, 7, 8: cp = 16'($urandom_range(16'hffff, 16'h0800));
            default: cp = edges[$urandom_range(7)];
        endcase
        send_word(1'b0, CH_BSLASH);
        send_word(1'b0, CH_U);
        send_hex_digits(cp, 4);
    endtask

    // A string literal with random content; a broken one ends in one of the error cases.
    task automatic send_string(input bit broken);
        logic [7:0] c;
        logic [7:0] letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
        send_word(1'b0, CH_QUOTE);
        repeat ($urandom_range(7)) begin
            case ($urandom_range(9))
                6, 7: begin
                    send_word(1'b0, CH_BSLASH);
                    send_word(1'b0, letters[$urandom_range(7)]);
                end
                8, 9: send_unicode();
                default: begin
                    // plain byte, high half included
                    do
                        c = 8'($urandom_range(8'hff, 8'h20));
                    while (c == CH_QUOTE || c == CH_BSLASH);
                    send_word(1'b0, c);
                end
            endcase
        end
        if (!broken)
            send_word(1'b0, CH_QUOTE);
        else begin
            case ($urandom_range(5))
                0: send_word(1'b0, 8'($urandom_range(8'h1f)));     // control byte
                1: begin                                           // unknown escape
                    do
                        c = 8'($urandom_range(255));
                    while (c inside {CH_QUOTE, CH_BSLASH, CH_U, "/", "b", "f", "n", "r", "t"});
                    send_word(1'b0, CH_BSLASH);
                    send_word(1'b0, c);
                end
                2: begin                                           // non-hex digit in \u
                    do
                        c = 8'($urandom_range(255));
                    while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
                    send_word(1'b0, CH_BSLASH);
                    send_word(1'b0, CH_U);
                    send_hex_digits(16'($urandom), $urandom_range(3));
                    send_word(1'b0, c);
                end
                3: send_word(1'b1, 8'($urandom));                  // unterminated
                4: begin                                           // ends after backslash
                    send_word(1'b0, CH_BSLASH);
                    send_word(1'b1, 8'($urandom));
                end
                default: begin                                     // ends inside \u
                    send_word(1'b0, CH_BSLASH);
                    send_word(1'b0, CH_U);
                    send_hex_digits(16'($urandom), $urandom_range(3));
                    send_word(1'b1, 8'($urandom));
                end
            endcase
        end
    endtask

    initial begin
        logic       eoi;
        logic [7:0] c;
        int         pick;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= 1'b0;
        in_if.data_byte  <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle errors, byte extremes, one- and three-byte UTF-8 decodes, escapes, each error case.
        send_word(1'b1, 8'hff);                    // end of input while idle
        send_word(1'b0, 8'h00);                    // stray byte while idle
        send_word(1'b0, CH_QUOTE);
        send_word(1'b0, 8'hff);                    // top-bit byte passes straight through
        send_word(1'b0, 8'h1f);                    // control byte kills the string
        send_text("\"\\uFfFf\\u0000\\n\\\"\"");    // 3-byte, single zero byte, escapes, done
        send_text("\"\\q");                        // unknown escape
        send_text("\"\\u0g");                      // bad hex digit
        send_text("\"\\");
        send_word(1'b1, 8'h00);                    // end after backslash
        send_text("\"\\u7");
        send_word(1'b1, 8'h5a);                    // end inside \u digits
        send_text("\"A");
        send_word(1'b1, 8'ha5);                    // unterminated
        hold_until_drained();

        // Random part in three idling phases: receiver-heavy, sender-heavy, none.
        words_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 34 : (ph == 1) ? 51 : 0;
            recv_stall_pct = (ph == 0) ? 51 : (ph == 1) ? 34 : 0;
            while (words_sent < (ph + 1) * RANDOM_WORDS / 3) begin
                pick = $urandom_range(9);
                if (pick < 7)
                    send_string(1'b0);
                else if (pick < 9)
                    send_string(1'b1);
                else begin
                    // noise while idle: anything but an opening quote
                    do begin
                        eoi = 1'($urandom_range(1));
                        c   = 8'($urandom);
                    end while (!eoi && c == CH_QUOTE);
                    send_word(eoi, c);
                end
                if ($urandom_range(11) == 0)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.faults == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
